[rtl/preemptive_periodic_task_scheduler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms for the periodic task scheduler.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PERIODIC_TASK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is held
`define PPTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held
`define PPTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppts_pkg.sv]
// ----------------------------------------------------------------------------
// Scheduler package
// Request and response types, action and status codes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ppts_pkg;

  // Default size of the task table
  localparam int unsigned MAX_TASK_COUNT_DEF = 16;

  // Tick rate after reset
  localparam logic [15:0] TICK_RATE_RST = 16'd1;

  // Action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_DONE = 2'd1;
  localparam logic [1:0] ACT_ADD  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IDLE_DONE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] period;
  } in_req_t;

  typedef struct packed {
    logic       dispatched;
    logic [3:0] task_index;
    logic [1:0] status;
  } out_rsp_t;

endpackage

`default_nettype wire

[rtl/preemptive_periodic_task_scheduler_unit.sv]
// Add, unused action or done with nothing running: the response is loaded
// directly. Tick: the scan steps through the entries until one is dispatched
// or the table ends, then loads the response. Done: the popped task is aged
// first and the scan resumes just after it. One request at a time; a stalled
// response holds the next. Reset (rst_n low, synchronous): nothing running,
// empty stack and table, tick rate 1; other entries undefined.
// ----------------------------------------------------------------------------
// Preemptive periodic task scheduler
// Fixed-priority dispatcher: a sequencer walks the task table, one entry per
// cycle, through one shared saturating adder and one ready compare.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_periodic_task_scheduler_unit
  import ppts_pkg::*;
#(
  parameter int unsigned MAX_TASK_COUNT = MAX_TASK_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_req_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_rsp_t         out_data
);

  `include "preemptive_periodic_task_scheduler_unit_defines.svh"

  localparam int unsigned IDX_W = (MAX_TASK_COUNT > 1) ? $clog2(MAX_TASK_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASK_COUNT + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASK_COUNT);

  // Responses that carry no dispatch
  localparam out_rsp_t RSP_OK        = '{dispatched: 1'b0, task_index: 4'd0,
                                         status: ST_OK};
  localparam out_rsp_t RSP_IDLE_DONE = '{dispatched: 1'b0, task_index: 4'd0,
                                         status: ST_IDLE_DONE};
  localparam out_rsp_t RSP_FULL      = '{dispatched: 1'b0, task_index: 4'd0,
                                         status: ST_FULL};

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUMP,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [15:0]       tick_rate_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  depth_r;
  logic [CNT_W-1:0]  cnt_r;
  out_rsp_t          res_r;
  logic              out_valid_r;
  out_rsp_t          out_data_r;

  logic [31:0]       period_r  [MAX_TASK_COUNT];
  logic [31:0]       elapsed_r [MAX_TASK_COUNT];
  logic [IDX_W-1:0]  stack_r   [MAX_TASK_COUNT];
  logic [MAX_TASK_COUNT-1:0] running_r;

  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  add_idx;
  logic [IDX_W-1:0]  top_idx;
  logic [CNT_W-1:0]  depth_m1;
  logic [CNT_W-1:0]  depth_inc;
  logic [31:0]       cur_elapsed;
  logic [31:0]       cur_period;
  logic [32:0]       sum;
  logic [31:0]       sat_sum;
  logic              outranks;
  logic              in_range;
  logic              can_run;
  logic              dispatch_now;
  logic              depth_ok;
  logic              slot_free;
  logic              in_fire;

  // Shared step unit: entry at the scan pointer, saturating add and ready test
  always_comb begin
    scan_idx     = cnt_r[IDX_W-1:0];
    add_idx      = count_r[IDX_W-1:0];
    depth_m1     = depth_r - CNT_W'(1);
    depth_inc    = depth_r + CNT_W'(1);
    top_idx      = stack_r[depth_m1[IDX_W-1:0]];
    cur_elapsed  = elapsed_r[scan_idx];
    cur_period   = period_r[scan_idx];
    sum          = {1'b0, cur_elapsed} + {17'b0, tick_rate_r};
    sat_sum      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    outranks     = (depth_r == '0) || (CNT_W'(top_idx) > cnt_r);
    in_range     = (cnt_r < count_r) && (cnt_r < MAX_CNT);
    can_run      = (cur_elapsed >= cur_period) && outranks &&
                   !running_r[scan_idx] && (depth_r < MAX_CNT);
    dispatch_now = (state_r == S_SCAN) && in_range && can_run;
    depth_ok     = (depth_r <= MAX_CNT) && (depth_r <= count_r);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_RATE_RST;
    end else if (cfg_we) begin
      tick_rate_r <= cfg_wdata;
    end
  end

  // Sequencer, task table and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      depth_r     <= '0;
      cnt_r       <= '0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // raise a loaded response, drop a delivered one
      if ((state_r == S_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data.action)
              ACT_TICK: begin
                res_r   <= RSP_OK;
                cnt_r   <= '0;
                state_r <= S_SCAN;
              end
              ACT_DONE: begin
                if (depth_r == '0) begin
                  res_r   <= RSP_IDLE_DONE;
                  state_r <= S_EMIT;
                end else begin
                  // pop the top task; its elapsed time is updated next
                  res_r   <= RSP_OK;
                  depth_r <= depth_m1;
                  cnt_r   <= CNT_W'(top_idx);
                  state_r <= S_BUMP;
                end
              end
              ACT_ADD: begin
                state_r <= S_EMIT;
                if (count_r >= MAX_CNT) begin
                  res_r <= RSP_FULL;
                end else begin
                  res_r              <= RSP_OK;
                  period_r[add_idx]  <= in_data.period;
                  elapsed_r[add_idx] <= in_data.period;
                  running_r[add_idx] <= 1'b0;
                  count_r            <= count_r + CNT_W'(1);
                end
              end
              default: begin
                res_r   <= RSP_OK;
                state_r <= S_EMIT;
              end
            endcase
          end
        end

        S_BUMP: begin
          // release the finished task and resume just after it
          running_r[scan_idx] <= 1'b0;
          elapsed_r[scan_idx] <= sat_sum;
          cnt_r               <= cnt_r + CNT_W'(1);
          state_r             <= S_SCAN;
        end

        S_SCAN: begin
          if (!in_range) begin
            state_r <= S_EMIT;
          end else if (can_run) begin
            // dispatch: clear elapsed time, push and report
            elapsed_r[scan_idx]         <= '0;
            running_r[scan_idx]         <= 1'b1;
            stack_r[depth_r[IDX_W-1:0]] <= scan_idx;
            depth_r                     <= depth_inc;
            res_r                       <= '{dispatched: 1'b1,
                                             task_index: 4'(scan_idx),
                                             status: ST_OK};
            state_r                     <= S_EMIT;
          end else begin
            elapsed_r[scan_idx] <= sat_sum;
            cnt_r               <= cnt_r + CNT_W'(1);
          end
        end

        S_EMIT: begin
          // hold the response until the output register is free
          if (slot_free) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Assertions
  `PPTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready, "accepted while busy")
  `PPTS_ASSERT_NOW(a_depth_bound, clk, rst_n, 1'b1, depth_ok, "stack deeper than table")
  `PPTS_ASSERT_NEXT(a_dispatch_push, clk, rst_n, dispatch_now, running_r[$past(scan_idx)], "no push")
  `PPTS_ASSERT_NEXT(a_dispatch_depth, clk, rst_n, dispatch_now, depth_r == $past(depth_inc), "no push")
  `PPTS_ASSERT_NOW(a_scan_in_bounds, clk, rst_n, state_r == S_BUMP, cnt_r < count_r, "pop off table")

endmodule

`default_nettype wire
